// ===== rtl/core/dmsn_pkg.sv =====
// shared widths, register indexes and constants of the surface normal block
package dmsn_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COL_W = 10;
	localparam int ROW_W = 12;
	localparam int NXY_W = 16;
	localparam int NZ_W = 15;
	localparam int MAG_W = 16;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int MAX_HEIGHT = 4096;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// normalizing unit: 33 quotient bits of num*2^32/den, then a 17-bit square root
	localparam int QUO_W = 33;
	localparam int RAD_W = 34;
	localparam int ROOT_W = 17;
	localparam int REM_W = 20;
	localparam int DIV_STEPS = 33;
	localparam int ROOT_STEPS = 17;
	localparam int STEP_W = 6;

	localparam logic [MAG_W-1:0] Q15_MAX = 16'h7FFF;

endpackage

// ===== rtl/core/dmsn_in_if.sv =====
// depth sample input channel
interface dmsn_in_if;
	logic valid;
	logic ready;
	logic [dmsn_pkg::SAMPLE_W-1:0] depth_sample;

	modport source(output valid, depth_sample, input ready);
	modport sink(input valid, depth_sample, output ready);
endinterface

// ===== rtl/core/dmsn_out_if.sv =====
// surface normal result channel
interface dmsn_out_if;
	logic valid;
	logic ready;
	logic [dmsn_pkg::COL_W-1:0] pixel_col;
	logic [dmsn_pkg::ROW_W-1:0] pixel_row;
	logic [dmsn_pkg::SAMPLE_W-1:0] pixel_depth;
	logic signed [dmsn_pkg::NXY_W-1:0] normal_x;
	logic signed [dmsn_pkg::NXY_W-1:0] normal_y;
	logic [dmsn_pkg::NZ_W-1:0] normal_z;
	logic last_of_run;
	logic frame_done;

	modport source(output valid, pixel_col, pixel_row, pixel_depth, normal_x, normal_y,
		normal_z, last_of_run, frame_done, input ready);
	modport sink(input valid, pixel_col, pixel_row, pixel_depth, normal_x, normal_y,
		normal_z, last_of_run, frame_done, output ready);
endinterface

// ===== rtl/core/dmsn_cfg_if.sv =====
// configuration register write channel
interface dmsn_cfg_if;
	logic valid;
	logic ready;
	logic [dmsn_pkg::CFG_IDX_W-1:0] index;
	logic [dmsn_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/depth_map_surface_normals.sv =====
// top level: streaming surface normals of a depth frame
// samples: one depth sample per beat in raster order, taken whenever the block
//   is idle. each beat is written to a three-row line store in the ram.
// normals: up to three results per input beat: the pixel above the new one,
//   and on the last row the pixel to the left and, at the row end, the pixel
//   itself. last_of_run marks the final result of a beat, frame_done the
//   frame's last pixel.
// cfg: index 0 frame_width, index 1 frame_height; either write restarts the
//   frame at column 0, row 0. ready is always high.
// timing: each result passes a pick step, the store reads, slope and square
//   arithmetic (diff, squares, sum), three passes of the normalizing unit
//   (x, y, z) and an output step; the normalizing unit takes the longest. no new
//   sample is taken until every result of the beat is in the output register.
// a finished result sits in the output register; while the receiver stalls
//   the block holds the next result and stops taking samples, the next
//   sample is still taken while the last result waits.
// reset clears position, rotation and handshake state; the store is not
//   cleared and needs no clearing pass.
module depth_map_surface_normals #(
	parameter int MAX_WIDTH = 1024,
	parameter int DEPTH_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	dmsn_in_if.sink       samples,
	dmsn_out_if.source    normals,
	dmsn_cfg_if.sink      cfg
);

	localparam int DW = DEPTH_BITS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = 2 * DW + 2;
	localparam int RAM_DEPTH = 3 * MAX_WIDTH;
	localparam int AW = $clog2(RAM_DEPTH);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PICK = 9'b000000010,
		S_READ = 9'b000000100,
		S_DIFF = 9'b000001000,
		S_SQA  = 9'b000010000,
		S_SQB  = 9'b000100000,
		S_SUM  = 9'b001000000,
		S_UNIT = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [dmsn_pkg::FW_W-1:0] frame_width_q;
	logic [dmsn_pkg::FH_W-1:0] frame_height_q;
	logic [CW-1:0] col_q;
	logic [dmsn_pkg::ROW_W-1:0] row_q;
	logic [1:0] rot_q;

	logic [CW-1:0] icol_q;
	logic [dmsn_pkg::ROW_W-1:0] irow_q;
	logic [1:0] cur_q;
	logic [2:0] jobs_q;

	logic [CW-1:0] ecol_q;
	logic [dmsn_pkg::ROW_W-1:0] erow_q;
	logic [1:0] mid_q, top_q, bot_q;
	logic has_l_q, has_r_q, has_u_q, has_d_q, done_q, last_q;
	logic [2:0] rd_cnt_q;
	logic [DW-1:0] c_q, l_q, r_q, u_q, d_q;
	logic neg_a_q, neg_b_q;
	logic [DW-1:0] ma_q, mb_q;
	logic [2*DW-1:0] ma2_q, mb2_q;
	logic [SW-1:0] s_q;
	logic [1:0] comp_q;
	logic ustart_q;
	logic signed [dmsn_pkg::NXY_W-1:0] nx_q, ny_q;
	logic [dmsn_pkg::NZ_W-1:0] nz_q;

	logic out_valid_q;
	logic [dmsn_pkg::COL_W-1:0] o_col_q;
	logic [dmsn_pkg::ROW_W-1:0] o_row_q;
	logic [dmsn_pkg::SAMPLE_W-1:0] o_depth_q;
	logic signed [dmsn_pkg::NXY_W-1:0] o_nx_q, o_ny_q;
	logic [dmsn_pkg::NZ_W-1:0] o_nz_q;
	logic o_last_q, o_done_q;

	logic [CW:0] w_eff;
	logic [dmsn_pkg::FH_W-1:0] h_eff;
	logic last_col, last_row, in_fire, out_load;
	logic [1:0] prev_row, prev2_row;
	logic [AW-1:0] waddr, raddr;
	logic [1:0] rsel;
	logic [CW-1:0] rcol;
	logic [DW-1:0] rdata;
	logic [2:0] sel;
	logic [CW-1:0] p_col;
	logic [dmsn_pkg::ROW_W-1:0] p_row;
	logic [1:0] p_mid, p_top, p_bot;
	logic p_has_u, p_has_d, p_done;
	logic signed [DW:0] diff_a, diff_b;
	logic [SW-1:0] unum;
	logic udone;
	logic [dmsn_pkg::MAG_W-1:0] umag;
	logic signed [dmsn_pkg::NXY_W-1:0] signed_mag;
	logic comp_neg;

	function automatic logic [AW-1:0] store_addr(input logic [1:0] r, input logic [CW-1:0] c);
		store_addr = AW'(32'(r) * MAX_WIDTH + 32'(c));
	endfunction

	function automatic logic [1:0] row_next(input logic [1:0] r);
		row_next = (r == 2'd2) ? 2'd0 : r + 2'd1;
	endfunction

	// clamp the programmed dimensions
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = (CW + 1)'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = (CW + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW + 1)'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = dmsn_pkg::FH_W'(1);
		end else if (32'(frame_height_q) > dmsn_pkg::MAX_HEIGHT) begin
			h_eff = dmsn_pkg::FH_W'(dmsn_pkg::MAX_HEIGHT);
		end else begin
			h_eff = frame_height_q;
		end
	end

	assign last_col = {1'b0, col_q} == w_eff - 1'b1;
	assign last_row = dmsn_pkg::FH_W'(row_q) == h_eff - 1'b1;
	assign in_fire = samples.valid && samples.ready;
	assign samples.ready = state_q == S_IDLE;
	assign cfg.ready = 1'b1;
	assign prev_row = row_next(row_next(cur_q));
	assign prev2_row = row_next(cur_q);
	assign waddr = store_addr(rot_q, col_q);

	// pick the next pending result of the current beat
	always_comb begin
		sel = 3'b000;
		p_col = icol_q;
		p_row = irow_q;
		p_mid = cur_q;
		p_top = prev_row;
		p_bot = cur_q;
		p_has_u = irow_q != '0;
		p_has_d = 1'b0;
		p_done = 1'b0;
		priority if (jobs_q[0]) begin
			sel = 3'b001;
			p_row = irow_q - 1'b1;
			p_mid = prev_row;
			p_top = prev2_row;
			p_has_u = p_row != '0;
			p_has_d = 1'b1;
		end else if (jobs_q[1]) begin
			sel = 3'b010;
			p_col = icol_q - 1'b1;
		end else begin
			sel = 3'b100;
			p_done = 1'b1;
		end
	end

	// store read address per read step
	always_comb begin
		rsel = mid_q;
		rcol = ecol_q;
		unique case (rd_cnt_q)
			3'd1: rcol = has_l_q ? ecol_q - 1'b1 : ecol_q;
			3'd2: rcol = has_r_q ? ecol_q + 1'b1 : ecol_q;
			3'd3: rsel = has_u_q ? top_q : mid_q;
			3'd4: rsel = has_d_q ? bot_q : mid_q;
			default: ;
		endcase
	end
	assign raddr = store_addr(rsel, rcol);

	dmsn_ram #(
		.WIDTH(DW),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (in_fire),
		.waddr(waddr),
		.wdata(DW'(samples.depth_sample)),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		unique case (comp_q)
			2'd0: unum = SW'(ma2_q);
			2'd1: unum = SW'(mb2_q);
			default: unum = SW'(4);
		endcase
	end

	dmsn_root #(
		.SW(SW)
	) u_root (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ustart_q),
		.num   (unum),
		.den   (s_q),
		.done  (udone),
		.mag   (umag)
	);

	assign diff_a = $signed({1'b0, l_q}) - $signed({1'b0, r_q});
	assign diff_b = $signed({1'b0, u_q}) - $signed({1'b0, d_q});
	assign comp_neg = (comp_q == 2'd0) ? neg_a_q : neg_b_q;
	assign signed_mag = comp_neg ? -$signed(umag)
		: (umag[dmsn_pkg::MAG_W-1] ? $signed(dmsn_pkg::Q15_MAX) : $signed(umag));
	assign out_load = (state_q == S_OUT) && (!out_valid_q || normals.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			frame_width_q <= dmsn_pkg::FRAME_WIDTH_RST;
			frame_height_q <= dmsn_pkg::FRAME_HEIGHT_RST;
			col_q <= '0;
			row_q <= '0;
			rot_q <= '0;
			jobs_q <= '0;
			rd_cnt_q <= '0;
			comp_q <= '0;
			ustart_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ustart_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (normals.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid && cfg.ready) begin
				if (cfg.index == dmsn_pkg::CFG_FRAME_WIDTH) begin
					frame_width_q <= cfg.data[dmsn_pkg::FW_W-1:0];
				end
				if (cfg.index == dmsn_pkg::CFG_FRAME_HEIGHT) begin
					frame_height_q <= cfg.data;
				end
				if (cfg.index == dmsn_pkg::CFG_FRAME_WIDTH
						|| cfg.index == dmsn_pkg::CFG_FRAME_HEIGHT) begin
					col_q <= '0;
					row_q <= '0;
					rot_q <= '0;
				end
			end else if (in_fire) begin
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q <= '0;
						rot_q <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						rot_q <= row_next(rot_q);
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						jobs_q <= {last_row && last_col, last_row && col_q != '0, row_q != '0};
						if (row_q != '0 || (last_row && (col_q != '0 || last_col))) begin
							state_q <= S_PICK;
						end
					end
				end
				S_PICK: begin
					jobs_q <= jobs_q & ~sel;
					rd_cnt_q <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					if (rd_cnt_q == 3'd5) begin
						state_q <= S_DIFF;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				S_DIFF: state_q <= S_SQA;
				S_SQA: state_q <= S_SQB;
				S_SQB: state_q <= S_SUM;
				S_SUM: begin
					comp_q <= '0;
					ustart_q <= 1'b1;
					state_q <= S_UNIT;
				end
				S_UNIT: begin
					if (udone) begin
						if (comp_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							comp_q <= comp_q + 1'b1;
							ustart_q <= 1'b1;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= (jobs_q != '0) ? S_PICK : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			icol_q <= col_q;
			irow_q <= row_q;
			cur_q <= rot_q;
		end
		if (state_q == S_PICK) begin
			ecol_q <= p_col;
			erow_q <= p_row;
			mid_q <= p_mid;
			top_q <= p_top;
			bot_q <= p_bot;
			has_l_q <= p_col != '0;
			has_r_q <= (CW + 1)'(p_col) + 1'b1 < w_eff;
			has_u_q <= p_has_u;
			has_d_q <= p_has_d;
			done_q <= p_done;
			last_q <= (jobs_q & ~sel) == '0;
		end
		if (state_q == S_READ) begin
			unique case (rd_cnt_q)
				3'd1: c_q <= rdata;
				3'd2: l_q <= rdata;
				3'd3: r_q <= rdata;
				3'd4: u_q <= rdata;
				3'd5: d_q <= rdata;
				default: ;
			endcase
		end
		if (state_q == S_DIFF) begin
			neg_a_q <= diff_a[DW];
			neg_b_q <= diff_b[DW];
			ma_q <= DW'(diff_a[DW] ? -diff_a : diff_a);
			mb_q <= DW'(diff_b[DW] ? -diff_b : diff_b);
		end
		if (state_q == S_SQA) begin
			ma2_q <= ma_q * ma_q;
		end
		if (state_q == S_SQB) begin
			mb2_q <= mb_q * mb_q;
		end
		if (state_q == S_SUM) begin
			s_q <= SW'(ma2_q) + SW'(mb2_q) + SW'(4);
		end
		if (state_q == S_UNIT && udone) begin
			if (comp_q == 2'd0) begin
				nx_q <= signed_mag;
			end
			if (comp_q == 2'd1) begin
				ny_q <= signed_mag;
			end
			if (comp_q == 2'd2) begin
				nz_q <= umag[dmsn_pkg::MAG_W-1] ? dmsn_pkg::NZ_W'(dmsn_pkg::Q15_MAX)
					: dmsn_pkg::NZ_W'(umag);
			end
		end
		if (out_load) begin
			o_col_q <= dmsn_pkg::COL_W'(ecol_q);
			o_row_q <= erow_q;
			o_depth_q <= dmsn_pkg::SAMPLE_W'(c_q);
			o_nx_q <= nx_q;
			o_ny_q <= ny_q;
			o_nz_q <= nz_q;
			o_last_q <= last_q;
			o_done_q <= done_q;
		end
	end

	assign normals.valid = out_valid_q;
	assign normals.pixel_col = o_col_q;
	assign normals.pixel_row = o_row_q;
	assign normals.pixel_depth = o_depth_q;
	assign normals.normal_x = o_nx_q;
	assign normals.normal_y = o_ny_q;
	assign normals.normal_z = o_nz_q;
	assign normals.last_of_run = o_last_q;
	assign normals.frame_done = o_done_q;

endmodule

// ===== rtl/core/dmsn_ram.sv =====
// generic single write port ram with registered read
module dmsn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 3072
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/dmsn_root.sv =====
// iterative unit: round(sqrt(num/den)) in q1.15 by long division then bitwise square root
module dmsn_root #(
	parameter int SW = 34
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SW-1:0]                num,
	input  logic [SW-1:0]                den,
	output logic                         done,
	output logic [dmsn_pkg::MAG_W-1:0]   mag
);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_DIV  = 3'b010,
		U_ROOT = 3'b100
	} ustate_t;

	ustate_t state_q;
	logic [dmsn_pkg::STEP_W-1:0] cnt_q;
	logic [SW-1:0] den_q;
	logic [SW-1:0] rem_q;
	logic lsb_q;
	logic [dmsn_pkg::QUO_W-1:0] quo_q;
	logic [dmsn_pkg::RAD_W-1:0] rad_q;
	logic [dmsn_pkg::REM_W-1:0] rrem_q;
	logic [dmsn_pkg::ROOT_W-1:0] root_q;

	logic [SW:0] sh;
	logic ge;
	logic [SW-1:0] rem_nx;
	logic [dmsn_pkg::QUO_W-1:0] quo_nx;
	logic [dmsn_pkg::REM_W+1:0] rsh;
	logic [dmsn_pkg::REM_W+1:0] trial;
	logic ge2;
	logic [dmsn_pkg::REM_W-1:0] rrem_nx;
	logic [dmsn_pkg::ROOT_W-1:0] root_nx;
	logic [dmsn_pkg::ROOT_W:0] half;

	always_comb begin
		sh = {rem_q, (cnt_q == '0) ? lsb_q : 1'b0};
		ge = sh >= {1'b0, den_q};
		rem_nx = ge ? SW'(sh - {1'b0, den_q}) : SW'(sh);
		quo_nx = {quo_q[dmsn_pkg::QUO_W-2:0], ge};

		rsh = {rrem_q, rad_q[dmsn_pkg::RAD_W-1 -: 2]};
		trial = (dmsn_pkg::REM_W + 2)'({root_q, 2'b01});
		ge2 = rsh >= trial;
		rrem_nx = ge2 ? dmsn_pkg::REM_W'(rsh - trial) : dmsn_pkg::REM_W'(rsh);
		root_nx = {root_q[dmsn_pkg::ROOT_W-2:0], ge2};
		half = ((dmsn_pkg::ROOT_W + 1)'(root_nx) + 1'b1) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						state_q <= U_DIV;
						cnt_q <= '0;
					end
				end
				U_DIV: begin
					if (cnt_q == dmsn_pkg::STEP_W'(dmsn_pkg::DIV_STEPS - 1)) begin
						state_q <= U_ROOT;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				U_ROOT: begin
					if (cnt_q == dmsn_pkg::STEP_W'(dmsn_pkg::ROOT_STEPS - 1)) begin
						state_q <= U_IDLE;
						done <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				den_q <= den;
				rem_q <= num >> 1;
				lsb_q <= num[0];
				quo_q <= '0;
			end
			U_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				rad_q <= {1'b0, quo_nx};
				rrem_q <= '0;
				root_q <= '0;
			end
			U_ROOT: begin
				rad_q <= rad_q << 2;
				rrem_q <= rrem_nx;
				root_q <= root_nx;
				mag <= dmsn_pkg::MAG_W'(half);
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/dmsn_normal_checker.sv =====
// checker: predicts surface normals from observed beats and compares results
module dmsn_normal_checker (
	input  logic clk,
	input  logic arst_n,
	dmsn_in_if   samples,
	dmsn_out_if  normals,
	dmsn_cfg_if  cfg,
	output int   fail_count,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [dmsn_pkg::COL_W-1:0] col;
		logic [dmsn_pkg::ROW_W-1:0] row;
		logic [dmsn_pkg::SAMPLE_W-1:0] depth;
		logic [dmsn_pkg::NXY_W-1:0] nx;
		logic [dmsn_pkg::NXY_W-1:0] ny;
		logic [dmsn_pkg::NZ_W-1:0] nz;
		logic last;
		logic done;
	} normal_t;

	localparam int LINE_LEN = 1024;

	logic [dmsn_pkg::SAMPLE_W-1:0] line_store [3][LINE_LEN];
	int unsigned frame_w, frame_h, col_pos, row_pos, rotation;
	normal_t normals_due [$];

	assign pending = normals_due.size();

	// largest q such that ((2q-1)/2^16)^2 <= num_sq / s, i.e. round(2^15 * sqrt(num_sq/s))
	function automatic int unit_mag(logic [63:0] num_sq, logic [127:0] s);
		int lo, hi, mid;
		logic [127:0] odd, rhs, prod;
		lo = 0;
		hi = 32768;
		rhs = {64'd0, num_sq} << 32;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 128'(2 * mid - 1);
			prod = s * (odd * odd);
			if (prod <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic logic [15:0] to_q15(longint d, int mag);
		if (d < 0) return 16'(65536 - mag);
		return (mag > 32767) ? 16'h7FFF : 16'(mag);
	endfunction

	function automatic normal_t surface_normal(int c, int r, int w, int h, int mid, int top,
			int bot, logic done);
		normal_t res;
		longint ctr, lf, rt, up, dn, a, b;
		longint unsigned ma, mb;
		logic [127:0] s;
		int z;
		ctr = longint'(line_store[mid][c]);
		lf = (c > 0) ? longint'(line_store[mid][c-1]) : ctr;
		rt = (c + 1 < w) ? longint'(line_store[mid][c+1]) : ctr;
		up = (r > 0) ? longint'(line_store[top][c]) : ctr;
		dn = (r + 1 < h) ? longint'(line_store[bot][c]) : ctr;
		a = lf - rt;
		b = up - dn;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		s = 128'(ma * ma) + 128'(mb * mb) + 128'd4;
		z = unit_mag(64'd4, s);
		res.col = dmsn_pkg::COL_W'(c);
		res.row = dmsn_pkg::ROW_W'(r);
		res.depth = dmsn_pkg::SAMPLE_W'(ctr);
		res.nx = to_q15(a, unit_mag(ma * ma, s));
		res.ny = to_q15(b, unit_mag(mb * mb, s));
		res.nz = (z > 32767) ? 15'h7FFF : dmsn_pkg::NZ_W'(z);
		res.last = 1'b0;
		res.done = done;
		return res;
	endfunction

	task automatic predict_normals(input logic [dmsn_pkg::SAMPLE_W-1:0] smp);
		int w, h, c, r, cur, prv, prv2, n;
		normal_t res [3];
		w = (frame_w < 1) ? 1 : ((frame_w > LINE_LEN) ? LINE_LEN : int'(frame_w));
		h = (frame_h < 1) ? 1
			: ((frame_h > dmsn_pkg::MAX_HEIGHT) ? dmsn_pkg::MAX_HEIGHT : int'(frame_h));
		c = (col_pos >= w) ? w - 1 : int'(col_pos);
		r = (row_pos >= h) ? h - 1 : int'(row_pos);
		cur = rotation % 3;
		prv = (cur + 2) % 3;
		prv2 = (cur + 1) % 3;
		n = 0;
		line_store[cur][c] = smp;
		if (r > 0) begin
			res[n] = surface_normal(c, r - 1, w, h, prv, prv2, cur, 1'b0);
			n++;
		end
		if (r == h - 1) begin
			if (c > 0) begin
				res[n] = surface_normal(c - 1, r, w, h, cur, prv, cur, 1'b0);
				n++;
			end
			if (c == w - 1) begin
				res[n] = surface_normal(c, r, w, h, cur, prv, cur, 1'b1);
				n++;
			end
		end
		if (n > 0) res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) normals_due = {normals_due, res[i]};
		if (c == w - 1) begin
			col_pos = 0;
			if (r == h - 1) begin
				row_pos = 0;
				rotation = 0;
			end else begin
				row_pos = r + 1;
				rotation = (cur + 1) % 3;
			end
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		normal_t got, want;
		if (!arst_n) begin
			frame_w = dmsn_pkg::FRAME_WIDTH_RST;
			frame_h = dmsn_pkg::FRAME_HEIGHT_RST;
			col_pos = 0;
			row_pos = 0;
			rotation = 0;
			fail_count = 0;
			checked = 0;
			normals_due.delete();
		end else begin
			if (normals.valid && normals.ready) begin
				got = {normals.pixel_col, normals.pixel_row, normals.pixel_depth,
					normals.normal_x, normals.normal_y, normals.normal_z,
					normals.last_of_run, normals.frame_done};
				checked++;
				if (normals_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected normal beat col %0d row %0d", got.col, got.row);
				end else begin
					want = normals_due.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: exp col %0d row %0d d %h nx %h ny %h nz %h l %b f %b",
								want.col, want.row, want.depth, want.nx, want.ny, want.nz,
								want.last, want.done);
							$display("          got col %0d row %0d d %h nx %h ny %h nz %h l %b f %b",
								got.col, got.row, got.depth, got.nx, got.ny, got.nz,
								got.last, got.done);
						end
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == dmsn_pkg::CFG_FRAME_WIDTH) begin
					frame_w = cfg.data[dmsn_pkg::FW_W-1:0];
					col_pos = 0;
					row_pos = 0;
					rotation = 0;
				end else if (cfg.index == dmsn_pkg::CFG_FRAME_HEIGHT) begin
					frame_h = cfg.data;
					col_pos = 0;
					row_pos = 0;
					rotation = 0;
				end
			end
			if (samples.valid && samples.ready) predict_normals(samples.depth_sample);
		end
	end
endmodule

// ===== tb/depth_map_surface_normals_tb.sv =====
// testbench top: clock, reset, frame stimulus and verdict for the surface normal block
module depth_map_surface_normals_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [dmsn_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [dmsn_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int SETTLE_CYCLES = 600;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic calm;
	int fail_count, pending, checked;
	int sent, frame_setups, quiet_cycles;
	logic [dmsn_pkg::SAMPLE_W-1:0] last_depth;

	dmsn_in_if  samples ();
	dmsn_out_if normals ();
	dmsn_cfg_if cfg ();

	depth_map_surface_normals dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .normals(normals), .cfg(cfg)
	);

	dmsn_normal_checker checker_i (
		.clk(clk), .arst_n(arst_n), .samples(samples), .normals(normals), .cfg(cfg),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		normals.ready <= calm || ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (normals.valid && normals.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [dmsn_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= dmsn_pkg::CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [dmsn_pkg::SAMPLE_W-1:0] d);
		while (!calm && $urandom_range(99) < 6) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.depth_sample <= d;
		do @(posedge clk); while (!samples.ready);
		sent++;
		last_depth = d;
	endtask

	task automatic settle();
		samples.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input int w, input int h);
		settle();
		write_reg(dmsn_pkg::CFG_FRAME_WIDTH, w);
		write_reg(dmsn_pkg::CFG_FRAME_HEIGHT, h);
		frame_setups++;
	endtask

	// styles: noise, gentle slope, flat, extremes
	task automatic send_pixels(input int n, input int style);
		logic [dmsn_pkg::SAMPLE_W-1:0] d;
		int st;
		for (int i = 0; i < n; i++) begin
			st = (style < 0) ? (($urandom_range(9) < 4) ? 0 : $urandom_range(3)) : style;
			case (st)
				0: d = dmsn_pkg::SAMPLE_W'($urandom);
				1: d = last_depth + dmsn_pkg::SAMPLE_W'($urandom_range(64)) - 16'd32;
				2: d = last_depth;
				default: d = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			endcase
			send_sample(d);
		end
	endtask

	initial begin
		int w, h, frames, budget, n;
		arst_n = 1'b0;
		calm = 1'b0;
		sent = 0;
		frame_setups = 0;
		last_depth = '0;
		samples.valid = 1'b0;
		samples.depth_sample = '0;
		cfg.valid = 1'b0;
		cfg.index = dmsn_pkg::CFG_FRAME_WIDTH;
		cfg.data = '0;
		normals.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry, first row only
		send_pixels(6, 0);
		set_frame(3, 3);
		send_pixels(3, 3);
		send_pixels(3, 2);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		set_frame(1, 1);
		send_pixels(2, 2);
		send_sample(16'hFFFF);
		set_frame(0, 0);
		send_pixels(2, 0);
		// tall frame restarted part way
		set_frame(2, 8191);
		send_pixels(6, 3);
		settle();
		write_reg(CFG_SPARE_A, 8191);
		write_reg(CFG_SPARE_B, 0);
		send_pixels(2, 1);
		set_frame(1, 4096);
		send_pixels(4, -1);

		budget = 220;
		while (budget > 0) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			h = $urandom_range(1, 10);
			frames = $urandom_range(1, 2);
			set_frame(w, h);
			if ($urandom_range(4) == 0) begin
				n = $urandom_range(1, w * h);
				send_pixels(n, -1);
				budget -= n;
			end else begin
				send_pixels(frames * w * h, -1);
				budget -= frames * w * h;
			end
		end

		// clamped width, start of a single row, no idling on either side
		calm = 1'b1;
		set_frame(2047, 1);
		send_pixels(40, -1);
		calm = 1'b0;

		settle();
		$display("sent %0d depth samples over %0d frame geometries", sent, frame_setups);
		$display("checked %0d normal beats", checked);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== depth_map_surface_normals.f =====
rtl/core/dmsn_pkg.sv
rtl/core/dmsn_in_if.sv
rtl/core/dmsn_out_if.sv
rtl/core/dmsn_cfg_if.sv
rtl/core/dmsn_ram.sv
rtl/core/dmsn_root.sv
rtl/core/depth_map_surface_normals.sv
tb/dmsn_normal_checker.sv
tb/depth_map_surface_normals_tb.sv
